// ===== rtl/jacobi_linear_solver_unit_defines.svh =====
// Assertion helpers for the solver RTL.
`ifndef JACOBI_LINEAR_SOLVER_UNIT_DEFINES_SVH
`define JACOBI_LINEAR_SOLVER_UNIT_DEFINES_SVH

// Same-cycle implication.
`define JLS_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define JLS_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/jls_pkg.sv =====
package jls_pkg;

   localparam int MAX_SIZE = 16;
   localparam int IDX_W    = $clog2(MAX_SIZE);
   localparam int CNT_W    = IDX_W + 1;
   localparam int ADDR_W   = 2 * IDX_W;
   localparam int DATA_W   = 32;
   localparam int FRAC_W   = 16;

   typedef logic signed [DATA_W-1:0] q16_type;

   typedef enum logic [1:0] {
      OP_LOAD_COEF = 2'd0,
      OP_LOAD_RHS  = 2'd1,
      OP_SOLVE     = 2'd2
   } opcode_type;

   typedef enum logic [1:0] {
      STAT_CONVERGED = 2'd0,
      STAT_LIMIT     = 2'd1,
      STAT_ZERO_DIAG = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      CSR_SIZE  = 2'd0,
      CSR_TOL   = 2'd1,
      CSR_LIMIT = 2'd2
   } csr_index_type;

   localparam logic [4:0]  SIZE_RESET  = 5'd16;
   localparam logic [30:0] TOL_RESET   = 31'd32768;
   localparam logic [7:0]  LIMIT_RESET = 8'd50;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DIAG_RD,
      S_DIAG_CHK,
      S_ROW_RD,
      S_ROW_D,
      S_BETA_WAIT,
      S_ALPHA_RD,
      S_ALPHA_DIV,
      S_ALPHA_WAIT,
      S_ROW_START,
      S_MAC,
      S_DRAIN,
      S_ROW_END,
      S_CHANGE,
      S_CHECK,
      S_OUT
   } solve_state_type;

   typedef enum logic [2:0] {
      CELL_HOLD,
      CELL_LOAD,
      CELL_ROT_PREV,
      CELL_PUSH,
      CELL_ROT_PAIR,
      CELL_ROT_CUR,
      CELL_COPY
   } cell_op_type;

endpackage

// ===== rtl/jls_req_if.sv =====
interface jls_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  opcode;
   logic [3:0]  row;
   logic [3:0]  column;
   logic signed [31:0] value;

   modport source (output valid, opcode, row, column, value, input ready);
   modport sink   (input valid, opcode, row, column, value, output ready);
endinterface

// ===== rtl/jls_rsp_if.sv =====
interface jls_rsp_if;
   logic        valid;
   logic        ready;
   logic [3:0]  solution_index;
   logic signed [31:0] solution_value;
   logic        last;
   logic [7:0]  iterations;
   logic [1:0]  status;

   modport source (output valid, solution_index, solution_value, last, iterations, status,
                   input ready);
   modport sink   (input valid, solution_index, solution_value, last, iterations, status,
                   output ready);
endinterface

// ===== rtl/jls_csr_if.sv =====
interface jls_csr_if;
   logic        valid;
   logic        ready;
   logic [1:0]  index;
   logic [31:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/jls_cell.sv =====
module jls_cell (
   input  logic                 clock,
   input  jls_pkg::cell_op_type op,
   input  jls_pkg::q16_type     prev_nxt,
   input  jls_pkg::q16_type     cur_nxt,
   input  jls_pkg::q16_type     beta_nxt,
   output jls_pkg::q16_type     prev,
   output jls_pkg::q16_type     cur,
   output jls_pkg::q16_type     beta
);

   jls_pkg::q16_type prev_ff, prev_in;
   jls_pkg::q16_type cur_ff, cur_in;
   jls_pkg::q16_type beta_ff, beta_in;

   always_comb begin
      prev_in = prev_ff;
      cur_in  = cur_ff;
      beta_in = beta_ff;
      unique case (op)
         jls_pkg::CELL_LOAD: begin
            prev_in = prev_nxt;
            cur_in  = cur_nxt;
            beta_in = beta_nxt;
         end
         jls_pkg::CELL_ROT_PREV: prev_in = prev_nxt;
         jls_pkg::CELL_PUSH: begin
            cur_in  = cur_nxt;
            beta_in = beta_nxt;
         end
         jls_pkg::CELL_ROT_PAIR: begin
            prev_in = prev_nxt;
            cur_in  = cur_nxt;
         end
         jls_pkg::CELL_ROT_CUR: cur_in = cur_nxt;
         jls_pkg::CELL_COPY: prev_in = cur_ff;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      prev_ff <= prev_in;
      cur_ff  <= cur_in;
      beta_ff <= beta_in;
   end

   assign prev = prev_ff;
   assign cur  = cur_ff;
   assign beta = beta_ff;

endmodule

// ===== rtl/jls_div.sv =====
module jls_div (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic             negate,
   input  jls_pkg::q16_type num,
   input  jls_pkg::q16_type den,
   output logic             busy,
   output logic             done,
   output jls_pkg::q16_type quot
);

   localparam int DW   = jls_pkg::DATA_W;
   localparam int Q_W  = jls_pkg::DATA_W + jls_pkg::FRAC_W;
   localparam int ST_W = $clog2(Q_W);

   logic            busy_ff, busy_in;
   logic            done_ff, done_in;
   logic [ST_W-1:0] cnt_ff, cnt_in;
   logic [Q_W-1:0]  q_ff, q_in;
   logic [DW:0]     rem_ff, rem_in;
   logic [DW-1:0]   den_ff, den_in;
   logic            neg_ff, neg_in;

   logic [DW-1:0]   num_mag, den_mag;
   logic [DW:0]     trial;
   logic            fits, big;

   assign num_mag = num[DW-1] ? DW'(-num) : DW'(num);
   assign den_mag = den[DW-1] ? DW'(-den) : DW'(den);
   assign trial   = {rem_ff[DW-1:0], q_ff[Q_W-1]};
   assign fits    = trial >= {1'b0, den_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      q_in    = q_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      neg_in  = neg_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         q_in    = {num_mag, {jls_pkg::FRAC_W{1'b0}}};
         rem_in  = '0;
         den_in  = den_mag;
         neg_in  = num[DW-1] ^ negate ^ den[DW-1];
      end else if (busy_ff) begin
         // one quotient bit per cycle, restoring
         rem_in = fits ? (trial - {1'b0, den_ff}) : trial;
         q_in   = {q_ff[Q_W-2:0], fits};
         cnt_in = cnt_ff + ST_W'(1);
         if (cnt_ff == ST_W'(Q_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      q_ff   <= q_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      neg_ff <= neg_in;
   end

   // magnitude at or above 2^31 saturates
   assign big = |q_ff[Q_W-1:DW-1];

   always_comb begin
      if (neg_ff) begin
         quot = big ? {1'b1, {(DW-1){1'b0}}} : jls_pkg::q16_type'(-q_ff[DW-1:0]);
      end else begin
         quot = big ? {1'b0, {(DW-1){1'b1}}} : jls_pkg::q16_type'(q_ff[DW-1:0]);
      end
   end

   assign busy = busy_ff;
   assign done = done_ff;

endmodule

// ===== rtl/jacobi_linear_solver_unit.sv =====
// Jacobi solver for A x = b in signed Q16.16, up to 16 unknowns.
// req_ch: opcode 0 writes a[row][column], 1 writes b[row], 2 starts a solve.
// Loads are taken one per cycle; the request channel stays busy during a solve.
// csr_ch: always ready; index 0 size, 1 tolerance, 2 iteration limit.
// rsp_ch: one transfer per unknown, index 0 first, last on the final one,
// each carrying the iteration count and status (0 converged, 1 limit, 2 zero
// diagonal).
// Steps of a solve with n unknowns and M = 16 rows in the cell row:
//   a diagonal check, then per active row one beta and n-1 alpha
//   quotients from a 48-step serial divider, then per iteration all M
//   rows through the shared multiplier while the previous iterate
//   circulates around the cell row.
// Reset returns to idle with default configuration; coefficient and rhs
// storage are not cleared. When the receiver stalls the current result holds
// and the cell row waits.
`include "jacobi_linear_solver_unit_defines.svh"

module jacobi_linear_solver_unit (
   input logic        clock,
   input logic        reset,
   jls_req_if.sink    req_ch,
   jls_rsp_if.source  rsp_ch,
   jls_csr_if.sink    csr_ch
);

   localparam int M      = jls_pkg::MAX_SIZE;
   localparam int IW     = jls_pkg::IDX_W;
   localparam int CW     = jls_pkg::CNT_W;
   localparam int DW     = jls_pkg::DATA_W;
   localparam int FW     = jls_pkg::FRAC_W;
   localparam int TERM_W = 2 * DW - FW;
   localparam int ACC_W  = TERM_W + IW + 1;
   localparam int CHG_W  = DW + 1 + IW;

   // configuration
   logic [4:0]  cfg_size_ff;
   logic [30:0] cfg_tol_ff;
   logic [7:0]  cfg_limit_ff;

   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_size_ff  <= jls_pkg::SIZE_RESET;
         cfg_tol_ff   <= jls_pkg::TOL_RESET;
         cfg_limit_ff <= jls_pkg::LIMIT_RESET;
      end else if (csr_ch.valid) begin
         unique case (csr_ch.index)
            jls_pkg::CSR_SIZE:  cfg_size_ff  <= csr_ch.data[4:0];
            jls_pkg::CSR_TOL:   cfg_tol_ff   <= csr_ch.data[30:0];
            jls_pkg::CSR_LIMIT: cfg_limit_ff <= csr_ch.data[7:0];
            default: ;
         endcase
      end
   end

   logic [CW-1:0] n_last;

   always_comb begin
      if (cfg_size_ff == '0) begin
         n_last = '0;
      end else if (32'(cfg_size_ff) > M) begin
         n_last = CW'(M - 1);
      end else begin
         n_last = CW'(32'(cfg_size_ff) - 32'd1);
      end
   end

   // state
   jls_pkg::solve_state_type state_ff, state_in;
   logic [CW-1:0]        i_ff, i_in, j_ff, j_in;
   logic                 drain_ff, drain_in;
   logic                 zero_ff, zero_in;
   logic [7:0]           done_ff, done_in;
   jls_pkg::status_type  status_ff, status_in;
   jls_pkg::q16_type     d_ff, d_in;
   logic [CHG_W-1:0]     chg_ff, chg_in;
   logic signed [ACC_W-1:0] acc_ff, acc_in;
   logic                 v1_ff, v1_in, v2_ff;
   jls_pkg::q16_type     xp_ff;
   logic signed [2*DW-1:0] prod_ff;

   logic [IW-1:0] i_idx, j_idx;
   assign i_idx = i_ff[IW-1:0];
   assign j_idx = j_ff[IW-1:0];

   logic req_fire, rsp_fire;
   assign req_fire = req_ch.valid && req_ch.ready;
   assign rsp_fire = rsp_ch.valid && rsp_ch.ready;

   // coefficient, rhs and alpha storage
   jls_pkg::q16_type coef_mem [M*M];
   jls_pkg::q16_type rhs_mem [M];
   jls_pkg::q16_type alpha_mem [M*M];
   jls_pkg::q16_type coef_rd_ff, rhs_rd_ff, alpha_rd_ff;
   logic [jls_pkg::ADDR_W-1:0] coef_raddr, alpha_raddr, coef_waddr;
   logic [IW-1:0]    rhs_raddr;
   logic             coef_we, rhs_we, alpha_we;
   jls_pkg::q16_type alpha_wdata;

   assign coef_we = req_fire && (req_ch.opcode == jls_pkg::OP_LOAD_COEF) &&
                    (32'(req_ch.row) < M) && (32'(req_ch.column) < M);
   assign rhs_we  = req_fire && (req_ch.opcode == jls_pkg::OP_LOAD_RHS) &&
                    (32'(req_ch.row) < M);
   assign coef_waddr = {IW'(req_ch.row), IW'(req_ch.column)};

   always_ff @(posedge clock) begin
      if (coef_we) coef_mem[coef_waddr] <= req_ch.value;
      coef_rd_ff <= coef_mem[coef_raddr];
   end

   always_ff @(posedge clock) begin
      if (rhs_we) rhs_mem[IW'(req_ch.row)] <= req_ch.value;
      rhs_rd_ff <= rhs_mem[rhs_raddr];
   end

   always_ff @(posedge clock) begin
      if (alpha_we) alpha_mem[{i_idx, j_idx}] <= alpha_wdata;
      alpha_rd_ff <= alpha_mem[alpha_raddr];
   end

   // divider
   logic             div_start, div_negate, div_busy, div_done;
   jls_pkg::q16_type div_num, div_den, div_quot;

   jls_div u_div (
      .clock  (clock),
      .reset  (reset),
      .start  (div_start),
      .negate (div_negate),
      .num    (div_num),
      .den    (div_den),
      .busy   (div_busy),
      .done   (div_done),
      .quot   (div_quot)
   );

   // cell row; cell 0 is the head, new values enter at the tail
   jls_pkg::cell_op_type cell_op;
   jls_pkg::q16_type     cell_tail;
   jls_pkg::q16_type     prev_q [M];
   jls_pkg::q16_type     cur_q [M];
   jls_pkg::q16_type     beta_q [M];
   jls_pkg::q16_type     prev_n [M];
   jls_pkg::q16_type     cur_n [M];
   jls_pkg::q16_type     beta_n [M];

   for (genvar k = 0; k < M; k++) begin : g_cell
      if (k == M - 1) begin : g_tail
         assign prev_n[k] = (cell_op == jls_pkg::CELL_LOAD) ? cell_tail : prev_q[0];
         assign cur_n[k]  = (cell_op == jls_pkg::CELL_LOAD || cell_op == jls_pkg::CELL_PUSH) ?
                            cell_tail : cur_q[0];
         assign beta_n[k] = (cell_op == jls_pkg::CELL_LOAD) ? cell_tail : beta_q[0];
      end else begin : g_mid
         assign prev_n[k] = prev_q[k+1];
         assign cur_n[k]  = cur_q[k+1];
         assign beta_n[k] = beta_q[k+1];
      end
      jls_cell u_cell (
         .clock    (clock),
         .op       (cell_op),
         .prev_nxt (prev_n[k]),
         .cur_nxt  (cur_n[k]),
         .beta_nxt (beta_n[k]),
         .prev     (prev_q[k]),
         .cur      (cur_q[k]),
         .beta     (beta_q[k])
      );
   end

   // multiply-accumulate datapath
   logic signed [TERM_W-1:0] term;
   logic signed [ACC_W-1:0]  beta_ext;
   logic [ACC_W-DW:0]        acc_hi;
   jls_pkg::q16_type         acc_sat;
   logic signed [DW:0]       diff;
   logic [DW:0]              absd;

   // dropping the fraction bits of a two's-complement product rounds to minus infinity
   assign term     = prod_ff[2*DW-1:FW];
   assign beta_ext = {{(ACC_W-DW){beta_q[0][DW-1]}}, beta_q[0]};
   assign acc_hi   = acc_ff[ACC_W-1:DW-1];

   always_comb begin
      if ((&acc_hi) || !(|acc_hi)) begin
         acc_sat = acc_ff[DW-1:0];
      end else if (acc_ff[ACC_W-1]) begin
         acc_sat = {1'b1, {(DW-1){1'b0}}};
      end else begin
         acc_sat = {1'b0, {(DW-1){1'b1}}};
      end
   end

   assign diff = {cur_q[0][DW-1], cur_q[0]} - {prev_q[0][DW-1], prev_q[0]};
   assign absd = diff[DW] ? (DW+1)'(-diff) : (DW+1)'(diff);

   always_ff @(posedge clock) begin
      xp_ff   <= prev_q[0];
      prod_ff <= alpha_rd_ff * xp_ff;
   end

   // sequencer
   always_comb begin
      state_in    = state_ff;
      i_in        = i_ff;
      j_in        = j_ff;
      drain_in    = drain_ff;
      zero_in     = zero_ff;
      done_in     = done_ff;
      status_in   = status_ff;
      d_in        = d_ff;
      chg_in      = chg_ff;
      acc_in      = v2_ff ? acc_ff + {{(ACC_W-TERM_W){term[TERM_W-1]}}, term} : acc_ff;
      v1_in       = 1'b0;
      cell_op     = jls_pkg::CELL_HOLD;
      cell_tail   = '0;
      coef_raddr  = '0;
      rhs_raddr   = '0;
      alpha_raddr = '0;
      alpha_we    = 1'b0;
      alpha_wdata = '0;
      div_start   = 1'b0;
      div_negate  = 1'b0;
      div_num     = '0;
      div_den     = '0;

      unique case (state_ff)
         jls_pkg::S_IDLE: begin
            if (req_fire && req_ch.opcode == jls_pkg::OP_SOLVE) begin
               i_in     = '0;
               zero_in  = 1'b0;
               state_in = jls_pkg::S_DIAG_RD;
            end
         end
         jls_pkg::S_DIAG_RD: begin
            if (i_ff > n_last) begin
               j_in = '0;
               i_in = '0;
               if (zero_ff) begin
                  status_in = jls_pkg::STAT_ZERO_DIAG;
                  done_in   = '0;
                  state_in  = jls_pkg::S_OUT;
               end else begin
                  state_in = jls_pkg::S_ROW_RD;
               end
            end else begin
               coef_raddr = {i_idx, i_idx};
               state_in   = jls_pkg::S_DIAG_CHK;
            end
         end
         jls_pkg::S_DIAG_CHK: begin
            if (coef_rd_ff == '0) zero_in = 1'b1;
            i_in     = i_ff + CW'(1);
            state_in = jls_pkg::S_DIAG_RD;
         end
         jls_pkg::S_ROW_RD: begin
            if (i_ff == CW'(M)) begin
               i_in    = '0;
               j_in    = '0;
               done_in = '0;
               if (cfg_limit_ff == '0) begin
                  status_in = jls_pkg::STAT_LIMIT;
                  state_in  = jls_pkg::S_OUT;
               end else begin
                  state_in = jls_pkg::S_ROW_START;
               end
            end else if (i_ff > n_last) begin
               // unused rows still shift through to keep the row aligned
               cell_op = jls_pkg::CELL_LOAD;
               i_in    = i_ff + CW'(1);
            end else begin
               coef_raddr = {i_idx, i_idx};
               rhs_raddr  = i_idx;
               state_in   = jls_pkg::S_ROW_D;
            end
         end
         jls_pkg::S_ROW_D: begin
            d_in      = coef_rd_ff;
            div_start = 1'b1;
            div_num   = rhs_rd_ff;
            div_den   = coef_rd_ff;
            state_in  = jls_pkg::S_BETA_WAIT;
         end
         jls_pkg::S_BETA_WAIT: begin
            if (div_done) begin
               cell_op   = jls_pkg::CELL_LOAD;
               cell_tail = div_quot;
               j_in      = '0;
               state_in  = jls_pkg::S_ALPHA_RD;
            end
         end
         jls_pkg::S_ALPHA_RD: begin
            if (j_ff > n_last) begin
               i_in     = i_ff + CW'(1);
               state_in = jls_pkg::S_ROW_RD;
            end else begin
               coef_raddr = {i_idx, j_idx};
               state_in   = jls_pkg::S_ALPHA_DIV;
            end
         end
         jls_pkg::S_ALPHA_DIV: begin
            if (j_ff == i_ff) begin
               alpha_we = 1'b1;
               j_in     = j_ff + CW'(1);
               state_in = jls_pkg::S_ALPHA_RD;
            end else begin
               div_start  = 1'b1;
               div_negate = 1'b1;
               div_num    = coef_rd_ff;
               div_den    = d_ff;
               state_in   = jls_pkg::S_ALPHA_WAIT;
            end
         end
         jls_pkg::S_ALPHA_WAIT: begin
            if (div_done) begin
               alpha_we    = 1'b1;
               alpha_wdata = div_quot;
               j_in        = j_ff + CW'(1);
               state_in    = jls_pkg::S_ALPHA_RD;
            end
         end
         jls_pkg::S_ROW_START: begin
            acc_in   = beta_ext;
            j_in     = '0;
            state_in = jls_pkg::S_MAC;
         end
         jls_pkg::S_MAC: begin
            alpha_raddr = {i_idx, j_idx};
            v1_in       = (i_ff <= n_last) && (j_ff <= n_last);
            cell_op     = jls_pkg::CELL_ROT_PREV;
            j_in        = j_ff + CW'(1);
            if (j_ff == CW'(M - 1)) begin
               drain_in = 1'b0;
               state_in = jls_pkg::S_DRAIN;
            end
         end
         jls_pkg::S_DRAIN: begin
            // wait out the read and multiply stages
            if (drain_ff) state_in = jls_pkg::S_ROW_END;
            else drain_in = 1'b1;
         end
         jls_pkg::S_ROW_END: begin
            cell_op   = jls_pkg::CELL_PUSH;
            cell_tail = acc_sat;
            i_in      = i_ff + CW'(1);
            if (i_ff == CW'(M - 1)) begin
               j_in     = '0;
               chg_in   = '0;
               state_in = jls_pkg::S_CHANGE;
            end else begin
               state_in = jls_pkg::S_ROW_START;
            end
         end
         jls_pkg::S_CHANGE: begin
            if (j_ff <= n_last) chg_in = chg_ff + CHG_W'(absd);
            cell_op = jls_pkg::CELL_ROT_PAIR;
            j_in    = j_ff + CW'(1);
            if (j_ff == CW'(M - 1)) state_in = jls_pkg::S_CHECK;
         end
         jls_pkg::S_CHECK: begin
            done_in = done_ff + 8'd1;
            j_in    = '0;
            if (chg_ff < CHG_W'(cfg_tol_ff)) begin
               status_in = jls_pkg::STAT_CONVERGED;
               state_in  = jls_pkg::S_OUT;
            end else if (8'(done_ff + 8'd1) == cfg_limit_ff) begin
               status_in = jls_pkg::STAT_LIMIT;
               state_in  = jls_pkg::S_OUT;
            end else begin
               cell_op  = jls_pkg::CELL_COPY;
               i_in     = '0;
               state_in = jls_pkg::S_ROW_START;
            end
         end
         jls_pkg::S_OUT: begin
            if (rsp_fire) begin
               cell_op = jls_pkg::CELL_ROT_CUR;
               j_in    = j_ff + CW'(1);
               if (j_ff == n_last) state_in = jls_pkg::S_IDLE;
            end
         end
         default: state_in = jls_pkg::S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= jls_pkg::S_IDLE;
         drain_ff <= 1'b0;
         v1_ff    <= 1'b0;
         v2_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         drain_ff <= drain_in;
         v1_ff    <= v1_in;
         v2_ff    <= v1_ff;
      end
      i_ff      <= i_in;
      j_ff      <= j_in;
      zero_ff   <= zero_in;
      done_ff   <= done_in;
      status_ff <= status_in;
      d_ff      <= d_in;
      chg_ff    <= chg_in;
      acc_ff    <= acc_in;
   end

   assign req_ch.ready = (state_ff == jls_pkg::S_IDLE);

   assign rsp_ch.valid          = (state_ff == jls_pkg::S_OUT);
   assign rsp_ch.solution_index = 4'(j_ff);
   assign rsp_ch.solution_value = (status_ff == jls_pkg::STAT_ZERO_DIAG) ? '0 : cur_q[0];
   assign rsp_ch.last           = (j_ff == n_last);
   assign rsp_ch.iterations     = done_ff;
   assign rsp_ch.status         = status_ff;

   `JLS_ASSERT_NXT(a_last_ends_run, clock, reset, rsp_fire && rsp_ch.last, state_ff == jls_pkg::S_IDLE, "result run did not end on last")
   `JLS_ASSERT_IMP(a_div_start_idle, clock, reset, div_start, !div_busy, "divider restarted while busy")
   `JLS_ASSERT_IMP(a_zero_diag_result, clock, reset, rsp_ch.valid && rsp_ch.status == jls_pkg::STAT_ZERO_DIAG, rsp_ch.solution_value == '0 && rsp_ch.iterations == '0, "zero diagonal result not cleared")
   `JLS_ASSERT_IMP(a_limit_count, clock, reset, rsp_ch.valid && rsp_ch.status == jls_pkg::STAT_LIMIT, rsp_ch.iterations == cfg_limit_ff, "limit status with wrong count")

endmodule

// ===== verif/jacobi_linear_solver_unit_checker.sv =====
`timescale 1ns / 100ps

module jacobi_linear_solver_unit_checker (
   input  logic clock,
   input  logic reset,
   jls_req_if   req,
   jls_rsp_if   rsp,
   jls_csr_if   csr,
   output int   mismatches,
   output int   outstanding
);

   typedef struct {
      logic [3:0]           index;
      jls_pkg::q16_type     value;
      logic                 last;
      logic [7:0]           iterations;
      jls_pkg::status_type  status;
   } solution_entry_type;

   solution_entry_type solution_q[$];

   jls_pkg::q16_type coef_mem[jls_pkg::MAX_SIZE][jls_pkg::MAX_SIZE];
   jls_pkg::q16_type rhs_mem[jls_pkg::MAX_SIZE];
   logic [4:0]  size_reg;
   logic [30:0] tol_reg;
   logic [7:0]  limit_reg;
   int          fail_count = 0;

   assign mismatches = fail_count;

   function automatic jls_pkg::q16_type clamp_q16(longint v);
      if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
      if (v < -64'sd2147483648) return 32'sh80000000;
      return jls_pkg::q16_type'(v);
   endfunction

   task automatic note_mismatch(string what, longint exp_v, longint act_v);
      fail_count++;
      if (fail_count <= 10)
         $display("%0t: %s mismatch: expected %0d, got %0d", $time, what, exp_v, act_v);
   endtask

   // Run the whole iteration at the moment the solve is accepted.
   task automatic predict_solution();
      int                   n;
      bit                   zero_diag;
      jls_pkg::q16_type     alpha[jls_pkg::MAX_SIZE][jls_pkg::MAX_SIZE];
      jls_pkg::q16_type     beta[jls_pkg::MAX_SIZE];
      jls_pkg::q16_type     prev_x[jls_pkg::MAX_SIZE];
      jls_pkg::q16_type     cur_x[jls_pkg::MAX_SIZE];
      int                   done;
      jls_pkg::status_type  stat;
      longint               acc;
      longint               change;
      longint               diff;
      longint               d;
      solution_entry_type   e;
      n = size_reg;
      if (n < 1) n = 1;
      if (n > jls_pkg::MAX_SIZE) n = jls_pkg::MAX_SIZE;
      zero_diag = 0;
      done = 0;
      stat = jls_pkg::STAT_LIMIT;
      for (int i = 0; i < jls_pkg::MAX_SIZE; i++) cur_x[i] = '0;
      for (int i = 0; i < n; i++)
         if (coef_mem[i][i] == 0) zero_diag = 1;
      if (zero_diag) begin
         stat = jls_pkg::STAT_ZERO_DIAG;
      end else begin
         for (int i = 0; i < n; i++) begin
            d = coef_mem[i][i];
            for (int j = 0; j < n; j++)
               alpha[i][j] = (i == j) ? '0 :
                             clamp_q16((-longint'(coef_mem[i][j]) * 65536) / d);
            beta[i] = clamp_q16((longint'(rhs_mem[i]) * 65536) / d);
            prev_x[i] = beta[i];
            cur_x[i] = beta[i];
         end
         while (done < limit_reg) begin
            for (int i = 0; i < n; i++) begin
               acc = beta[i];
               for (int j = 0; j < n; j++)
                  acc += (longint'(alpha[i][j]) * longint'(prev_x[j])) >>> 16;
               cur_x[i] = clamp_q16(acc);
            end
            done++;
            change = 0;
            for (int i = 0; i < n; i++) begin
               diff = longint'(cur_x[i]) - longint'(prev_x[i]);
               change += (diff < 0) ? -diff : diff;
            end
            if (change < longint'(tol_reg)) begin
               stat = jls_pkg::STAT_CONVERGED;
               break;
            end
            prev_x = cur_x;
         end
      end
      for (int i = 0; i < n; i++) begin
         e.index = i[3:0];
         e.value = cur_x[i];
         e.last = (i == n - 1);
         e.iterations = done[7:0];
         e.status = stat;
         solution_q.push_back(e);
      end
   endtask

   always @(posedge clock) begin
      solution_entry_type e;
      if (reset) begin
         size_reg = jls_pkg::SIZE_RESET;
         tol_reg = jls_pkg::TOL_RESET;
         limit_reg = jls_pkg::LIMIT_RESET;
         solution_q.delete();
         outstanding <= 0;
      end else begin
         if (rsp.valid && rsp.ready) begin
            if (solution_q.size() == 0) begin
               note_mismatch("unexpected result, index", -1, rsp.solution_index);
            end else begin
               e = solution_q.pop_front();
               if (rsp.solution_index !== e.index)
                  note_mismatch("solution_index", e.index, rsp.solution_index);
               if (rsp.solution_value !== e.value)
                  note_mismatch("solution_value", e.value, rsp.solution_value);
               if (rsp.last !== e.last)
                  note_mismatch("last", e.last, rsp.last);
               if (rsp.iterations !== e.iterations)
                  note_mismatch("iterations", e.iterations, rsp.iterations);
               if (rsp.status !== e.status)
                  note_mismatch("status", e.status, rsp.status);
            end
         end
         if (csr.valid && csr.ready) begin
            case (jls_pkg::csr_index_type'(csr.index))
               jls_pkg::CSR_SIZE:  size_reg = csr.data[4:0];
               jls_pkg::CSR_TOL:   tol_reg = csr.data[30:0];
               jls_pkg::CSR_LIMIT: limit_reg = csr.data[7:0];
               default: ;
            endcase
         end
         if (req.valid && req.ready) begin
            case (jls_pkg::opcode_type'(req.opcode))
               jls_pkg::OP_LOAD_COEF: coef_mem[req.row][req.column] = req.value;
               jls_pkg::OP_LOAD_RHS:  rhs_mem[req.row] = req.value;
               jls_pkg::OP_SOLVE:     predict_solution();
               default: ;
            endcase
         end
         outstanding <= solution_q.size();
      end
   end

endmodule

// ===== verif/jacobi_linear_solver_unit_tb.sv =====
`timescale 1ns / 100ps

module jacobi_linear_solver_unit_tb;

   localparam logic [1:0] OP_UNUSED = 2'd3;
   localparam int HOLD_CYCLES = 15000;

   logic clock;
   logic reset;

   jls_req_if req_bus ();
   jls_rsp_if rsp_bus ();
   jls_csr_if csr_bus ();

   int  mismatches;
   int  outstanding;
   logic steady;
   logic long_hold;

   bit  coef_written[jls_pkg::MAX_SIZE][jls_pkg::MAX_SIZE];
   bit  rhs_written[jls_pkg::MAX_SIZE];
   int  size_raw = jls_pkg::SIZE_RESET;
   int  items_sent = 0;
   int  solves = 0;
   int  results_expected = 0;

   jacobi_linear_solver_unit uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_bus),
      .rsp_ch (rsp_bus),
      .csr_ch (csr_bus)
   );

   jacobi_linear_solver_unit_checker checker_inst (
      .clock       (clock),
      .reset       (reset),
      .req         (req_bus),
      .rsp         (rsp_bus),
      .csr         (csr_bus),
      .mismatches  (mismatches),
      .outstanding (outstanding)
   );

   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      #50_000_000;
      $display("TB_ERROR");
      $finish;
   end

   // Result side: random stalls, one long hold-off on request.
   initial begin
      int  hold_left;
      bit  hold_taken;
      hold_left = 0;
      hold_taken = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (reset) begin
            rsp_bus.ready <= 1'b0;
         end else if (long_hold && !hold_taken) begin
            hold_taken = 1;
            hold_left = HOLD_CYCLES;
            rsp_bus.ready <= 1'b0;
         end else if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= steady || ($urandom_range(99) >= 6);
         end
      end
   end

   function automatic int active_size();
      if (size_raw < 1) return 1;
      if (size_raw > jls_pkg::MAX_SIZE) return jls_pkg::MAX_SIZE;
      return size_raw;
   endfunction

   task automatic send_item(logic [1:0] op, int r, int c, logic [31:0] v);
      if (!steady && $urandom_range(99) < 6) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.opcode <= op;
      req_bus.row <= r[3:0];
      req_bus.column <= c[3:0];
      req_bus.value <= v;
      do @(posedge clock); while (!req_bus.ready);
      items_sent++;
      if (op == jls_pkg::OP_LOAD_COEF) coef_written[r[3:0]][c[3:0]] = 1;
      if (op == jls_pkg::OP_LOAD_RHS) rhs_written[r[3:0]] = 1;
   endtask

   task automatic wait_drained();
      req_bus.valid <= 1'b0;
      repeat (2) @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   task automatic write_reg(jls_pkg::csr_index_type idx, logic [31:0] d);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data <= d;
      do @(posedge clock); while (!csr_bus.ready);
      csr_bus.valid <= 1'b0;
      if (idx == jls_pkg::CSR_SIZE) size_raw = d[4:0];
   endtask

   // Never let a solve read a store entry that was not loaded.
   task automatic request_solve();
      int n;
      n = active_size();
      for (int i = 0; i < n; i++) begin
         for (int j = 0; j < n; j++)
            if (!coef_written[i][j]) send_item(jls_pkg::OP_LOAD_COEF, i, j, $urandom);
         if (!rhs_written[i]) send_item(jls_pkg::OP_LOAD_RHS, i, 0, $urandom);
      end
      send_item(jls_pkg::OP_SOLVE, $urandom_range(15), $urandom_range(15), $urandom);
      solves++;
      results_expected += n;
   endtask

   task automatic load_dominant(int n);
      int mag;
      for (int i = 0; i < n; i++) begin
         for (int j = 0; j < n; j++) begin
            if (i == j) begin
               mag = $urandom_range(n << 16, (n + 8) << 16);
               send_item(jls_pkg::OP_LOAD_COEF, i, j, $urandom_range(1) ? mag : -mag);
            end else begin
               send_item(jls_pkg::OP_LOAD_COEF, i, j, $urandom_range(65536) - 32768);
            end
         end
         send_item(jls_pkg::OP_LOAD_RHS, i, 0, $urandom_range(200 << 16) - (100 << 16));
      end
   endtask

   initial begin
      int  episode;
      int  pick;
      int  n;
      reset = 1'b1;
      steady = 1'b0;
      long_hold = 1'b0;
      req_bus.valid = 1'b0;
      req_bus.opcode = jls_pkg::OP_LOAD_COEF;
      req_bus.row = '0;
      req_bus.column = '0;
      req_bus.value = '0;
      csr_bus.valid = 1'b0;
      csr_bus.index = jls_pkg::CSR_SIZE;
      csr_bus.data = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      repeat (2) @(posedge clock);

      // Directed: zero diagonal, saturation both ways, unused opcode,
      // limit reached with zero tolerance, limit of zero.
      write_reg(jls_pkg::CSR_SIZE, 1);
      write_reg(jls_pkg::CSR_TOL, 32'h7FFF_FFFF);
      write_reg(jls_pkg::CSR_LIMIT, 1);
      send_item(jls_pkg::OP_LOAD_COEF, 0, 0, 0);
      send_item(jls_pkg::OP_LOAD_RHS, 0, 0, 5 << 16);
      request_solve();
      send_item(jls_pkg::OP_LOAD_COEF, 0, 0, 1);
      send_item(jls_pkg::OP_LOAD_RHS, 0, 0, 32'h7FFF_FFFF);
      request_solve();
      send_item(jls_pkg::OP_LOAD_RHS, 0, 0, 32'h8000_0000);
      request_solve();
      send_item(OP_UNUSED, 15, 15, 32'hFFFF_FFFF);
      wait_drained();
      write_reg(jls_pkg::CSR_SIZE, 2);
      write_reg(jls_pkg::CSR_TOL, 0);
      write_reg(jls_pkg::CSR_LIMIT, 255);
      send_item(jls_pkg::OP_LOAD_COEF, 0, 0, 32'h8000_0000);
      send_item(jls_pkg::OP_LOAD_COEF, 0, 1, 32'h7FFF_FFFF);
      send_item(jls_pkg::OP_LOAD_COEF, 1, 0, 1 << 16);
      send_item(jls_pkg::OP_LOAD_COEF, 1, 1, 2 << 16);
      send_item(jls_pkg::OP_LOAD_RHS, 1, 0, -(3 << 16));
      request_solve();
      wait_drained();
      write_reg(jls_pkg::CSR_LIMIT, 0);
      request_solve();
      wait_drained();
      write_reg(jls_pkg::CSR_TOL, 1 << 16);
      write_reg(jls_pkg::CSR_LIMIT, 50);
      request_solve();

      // Full size through an oversized size value; the zero on the last
      // diagonal keeps the solve to a scan of the diagonal.
      wait_drained();
      write_reg(jls_pkg::CSR_SIZE, 31);
      for (int i = 0; i < jls_pkg::MAX_SIZE; i++)
         send_item(jls_pkg::OP_LOAD_COEF, i, i,
                   (i == jls_pkg::MAX_SIZE - 1) ? 0 : (i + 1) << 16);
      send_item(jls_pkg::OP_SOLVE, 0, 0, 0);
      solves++;
      results_expected += jls_pkg::MAX_SIZE;
      wait_drained();
      write_reg(jls_pkg::CSR_SIZE, 2);

      episode = 0;
      while ((items_sent < 100 || episode < 6) && episode < 300) begin
         steady <= (episode >= 2 && episode < 5);
         pick = $urandom_range(99);
         if (episode == 1 || pick < 55) begin
            wait_drained();
            n = ($urandom_range(19) == 0) ? 0 : $urandom_range(1, 4);
            write_reg(jls_pkg::CSR_SIZE, n);
            write_reg(jls_pkg::CSR_TOL, $urandom_range(1 << 8, 1 << 17));
            write_reg(jls_pkg::CSR_LIMIT, $urandom_range(1, 30));
            load_dominant(active_size());
            if (episode == 1) long_hold <= 1'b1;
            request_solve();
            // These loads stall behind the solve while results are held off.
            if (episode == 1)
               repeat (3)
                  send_item(jls_pkg::OP_LOAD_COEF, $urandom_range(15), $urandom_range(15),
                            $urandom);
         end else if (pick < 80) begin
            repeat ($urandom_range(3, 8))
               send_item($urandom_range(1) ? jls_pkg::OP_LOAD_COEF : jls_pkg::OP_LOAD_RHS,
                         $urandom_range(15), $urandom_range(15), $urandom);
         end else if (pick < 90) begin
            request_solve();
         end else begin
            n = active_size();
            send_item(jls_pkg::OP_LOAD_COEF,
                      $urandom_range(n - 1) * (jls_pkg::MAX_SIZE + 1) % jls_pkg::MAX_SIZE,
                      0, 0);
            pick = $urandom_range(n - 1);
            send_item(jls_pkg::OP_LOAD_COEF, pick, pick, 0);
            request_solve();
         end
         episode++;
      end
      steady <= 1'b0;

      wait_drained();
      repeat (100) @(posedge clock);
      $display("Covered %0d request transfers and %0d solves with %0d solution elements,",
               items_sent, solves, results_expected);
      $display("including zero diagonal, saturation, limit and oversized size cases.");
      if (mismatches == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/jls_pkg.sv
rtl/jls_req_if.sv
rtl/jls_rsp_if.sv
rtl/jls_csr_if.sv
rtl/jls_cell.sv
rtl/jls_div.sv
rtl/jacobi_linear_solver_unit.sv
verif/jacobi_linear_solver_unit_checker.sv
verif/jacobi_linear_solver_unit_tb.sv
